// ----- src/msps_pkg.sv -----
// Shared types, codes and the coil table for the stepper phase sequencer.
`timescale 1ns / 1ps
`default_nettype none

package msps_pkg;

    localparam int CHANNELS = 4;
    localparam int MAX_CH   = 4;
    localparam int IDX_W    = 2;
    localparam int POS_W    = 16;
    localparam int COIL_W   = 4 * MAX_CH;
    localparam int IN_W     = 24;
    localparam int OUT_W    = 24;

    typedef enum logic [1:0] {
        REQ_TICK = 2'd0,
        REQ_REL  = 2'd1,
        REQ_ABS  = 2'd2,
        REQ_HOME = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_MOVING = 2'd1,
        MODE_HOMING = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2
    } dir_t;

    typedef struct packed {
        req_kind_t         kind;
        logic [IDX_W-1:0]  stepper_index;
        logic signed [7:0] step_count;
        logic [7:0]        target_position;
        logic [3:0]        limit_switches;
    } req_t;

    typedef struct packed {
        logic       busy;
        logic       active;
        logic [3:0] nibble;
    } lane_status_t;

    function automatic logic [3:0] coil_pattern(input logic [1:0] phase);
        logic [3:0] pat;
        case (phase)
            2'd0:    pat = 4'b1010;
            2'd1:    pat = 4'b0110;
            2'd2:    pat = 4'b0101;
            default: pat = 4'b1001;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

// ----- src/msps_lane.sv -----
// One stepper channel: mode, direction, phase, position, target and coil nibble.
`timescale 1ns / 1ps
`default_nettype none

module msps_lane (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire msps_pkg::req_t              req,
    input  wire logic [msps_pkg::IDX_W-1:0]  lane_id,
    output msps_pkg::lane_status_t           status
);
    import msps_pkg::*;

    mode_t             mode_reg, mode_next;
    dir_t              dir_reg, dir_next;
    logic [1:0]        phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  tgt_reg, tgt_next;
    logic [3:0]        nibble_reg, nibble_next;

    logic              tick, cmd, lim, do_step, do_clear, zero_pos;
    logic [1:0]        step_phase;
    logic [POS_W-1:0]  step_pos;

    assign tick = accept && (req.kind == REQ_TICK);
    assign cmd  = accept && (req.kind != REQ_TICK) && (req.stepper_index == lane_id);
    assign lim  = req.limit_switches[lane_id];

    assign do_step  = tick && (((mode_reg == MODE_MOVING) && (pos_reg != tgt_reg))
                            || ((mode_reg == MODE_HOMING) && lim));
    assign zero_pos = tick && (mode_reg == MODE_HOMING) && !lim;
    assign do_clear = zero_pos
                   || (tick && (mode_reg == MODE_MOVING) && (pos_reg == tgt_reg))
                   || (do_step && (dir_reg == DIR_NONE));

    assign step_phase = (dir_reg == DIR_CW) ? phase_reg + 2'd1 : phase_reg - 2'd1;
    assign step_pos   = (dir_reg == DIR_CW) ? pos_reg + POS_W'(1) : pos_reg - POS_W'(1);

    always_comb
    begin
        mode_next   = mode_reg;
        dir_next    = dir_reg;
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        tgt_next    = tgt_reg;
        nibble_next = nibble_reg;
        if (do_step)
        begin
            pos_next = step_pos;
            if (dir_reg != DIR_NONE)
            begin
                phase_next  = step_phase;
                nibble_next = coil_pattern(step_phase);
            end
        end
        if (do_clear)
        begin
            mode_next   = MODE_IDLE;
            dir_next    = DIR_NONE;
            nibble_next = 4'd0;
        end
        if (zero_pos)
        begin
            pos_next = '0;
        end
        if (cmd)
        begin
            case (req.kind)
                REQ_REL:
                begin
                    mode_next = MODE_MOVING;
                    dir_next  = (!req.step_count[7] && (req.step_count != 8'sd0))
                              ? DIR_CW : DIR_CCW;
                    tgt_next  = pos_reg + {{(POS_W-8){req.step_count[7]}}, req.step_count};
                end
                REQ_ABS:
                begin
                    mode_next = MODE_MOVING;
                    dir_next  = ({{(POS_W-8){1'b0}}, req.target_position} > pos_reg)
                              ? DIR_CW : DIR_CCW;
                    tgt_next  = {{(POS_W-8){1'b0}}, req.target_position};
                end
                REQ_HOME:
                begin
                    mode_next = MODE_HOMING;
                    dir_next  = DIR_CW;
                    tgt_next  = '0;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_HOMING;
            dir_reg    <= DIR_CW;
            phase_reg  <= 2'd0;
            pos_reg    <= '0;
            tgt_reg    <= '0;
            nibble_reg <= 4'd0;
        end
        else
        begin
            mode_reg   <= mode_next;
            dir_reg    <= dir_next;
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            tgt_reg    <= tgt_next;
            nibble_reg <= nibble_next;
        end
    end

    assign status.busy   = (mode_reg == MODE_MOVING) || (mode_reg == MODE_HOMING);
    assign status.active = (mode_next == MODE_MOVING) || (mode_next == MODE_HOMING);
    assign status.nibble = nibble_next;

endmodule

`default_nettype wire

// ----- src/msps_merge.sv -----
// Merges lane status into the coil word and flags, held in the output register.
`timescale 1ns / 1ps
`default_nettype none

module msps_merge (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic                          is_tick,
    input  wire msps_pkg::lane_status_t        status [msps_pkg::CHANNELS],
    input  wire logic                          out_ready,
    output logic                               in_ready,
    output logic                               out_valid,
    output logic [msps_pkg::COIL_W-1:0]        coil_word,
    output logic                               shift_out,
    output logic                               all_idle
);
    import msps_pkg::*;

    logic                valid_reg;
    logic [COIL_W-1:0]   coil_reg, coil_next;
    logic                shift_reg, shift_next;
    logic                idle_reg, idle_next;
    logic                any_busy;

    always_comb
    begin
        coil_next = '0;
        any_busy  = 1'b0;
        idle_next = 1'b1;
        for (int i = 0; i < CHANNELS; i++)
        begin
            coil_next[4*i +: 4] = status[i].nibble;
            any_busy            = any_busy | status[i].busy;
            idle_next           = idle_next & !status[i].active;
        end
        shift_next = is_tick && any_busy;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            coil_reg  <= coil_next;
            shift_reg <= shift_next;
            idle_reg  <= idle_next;
        end
    end

    assign out_valid = valid_reg;
    assign coil_word = coil_reg;
    assign shift_out = shift_reg;
    assign all_idle  = idle_reg;

endmodule

`default_nettype wire

// ----- src/multi_stepper_phase_sequencer_top.sv -----
// Top level of the multi-channel full-step stepper phase sequencer.
//
//  channel | beat carries                                   | handshake
//  s_      | tuser: req_type; tdata: index,count,target,lim | s_tvalid/s_tready
//  m_      | tdata: coil_word, shift_out, all_idle          | m_tvalid/m_tready
//
// One beat in per cycle while s_tready is high; its result appears in the output register in the next cycle.
// All channel lanes update in parallel in the accepting cycle.
// Reset puts every channel in homing, clockwise, phase 0, coils off.
// A stalled result holds the input only while m_tready is low and a result waits.
`timescale 1ns / 1ps
`default_nettype none

module multi_stepper_phase_sequencer_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [1:0] stepper_index, [9:2] step_count, [17:10] target_position,
    // [21:18] limit_switches, [23:22] zero
    input  wire logic [msps_pkg::IN_W-1:0]     s_tdata,
    // [1:0] req_type
    input  wire logic [1:0]                    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [15:0] coil_word, [16] shift_out, [17] all_idle, [23:18] zero
    output logic [msps_pkg::OUT_W-1:0]         m_tdata
);
    import msps_pkg::*;

    req_t            req;
    lane_status_t    status [CHANNELS];
    logic            accept;
    logic [COIL_W-1:0] coil_word;
    logic            shift_out, all_idle;

    assign accept              = s_tvalid && s_tready;
    assign req.kind            = req_kind_t'(s_tuser);
    assign req.stepper_index   = s_tdata[1:0];
    assign req.step_count      = s_tdata[9:2];
    assign req.target_position = s_tdata[17:10];
    assign req.limit_switches  = s_tdata[21:18];

    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_lane
        msps_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .accept  (accept),
            .req     (req),
            .lane_id (IDX_W'(i)),
            .status  (status[i])
        );
    end

    msps_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .is_tick   (req.kind == REQ_TICK),
        .status    (status),
        .out_ready (m_tready),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .coil_word (coil_word),
        .shift_out (shift_out),
        .all_idle  (all_idle)
    );

    assign m_tdata = {{(OUT_W-COIL_W-2){1'b0}}, all_idle, shift_out, coil_word};

    a_idle_coils_off: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[COIL_W+1]) |-> (m_tdata[COIL_W-1:0] == '0))
        else $error("all channels idle but coils energized");

    a_shift_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser != REQ_TICK)) |=> !m_tdata[COIL_W])
        else $error("shift flagged on a command beat");

    a_cmd_makes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser != REQ_TICK) && (32'(s_tdata[1:0]) < CHANNELS))
        |=> !m_tdata[COIL_W+1])
        else $error("command to a channel left all idle");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("accepted beat produced no result");

endmodule

`default_nettype wire

// ----- sim/stepper_sequencer_checker.sv -----
// Result checker for the stepper phase sequencer: predicts each coil beat and compares.
`timescale 1ns / 1ps

module stepper_sequencer_checker (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    input  wire logic                      s_tready,
    // [1:0] stepper_index, [9:2] step_count, [17:10] target_position,
    // [21:18] limit_switches, [23:22] zero
    input  wire logic [msps_pkg::IN_W-1:0] s_tdata,
    // [1:0] req_type
    input  wire logic [1:0]                s_tuser,
    input  wire logic                      m_tvalid,
    input  wire logic                      m_tready,
    // [15:0] coil_word, [16] shift_out, [17] all_idle, [23:18] zero
    input  wire logic [msps_pkg::OUT_W-1:0] m_tdata,
    output int                             errors,
    output int                             pending
);
    import msps_pkg::*;

    typedef struct packed {
        logic [15:0] coils;
        logic        shift;
        logic        all_idle;
    } coil_beat_t;

    // phase 3..0 from the top nibble down
    localparam logic [15:0] PHASE_COILS = {4'b1001, 4'b0101, 4'b0110, 4'b1010};

    mode_t       lane_mode  [MAX_CH];
    dir_t        lane_dir   [MAX_CH];
    logic [1:0]  lane_phase [MAX_CH];
    logic [15:0] lane_pos   [MAX_CH];
    logic [15:0] lane_tgt   [MAX_CH];
    logic [15:0] coil_word;
    coil_beat_t  coil_beats_q[$];
    int          mismatches;

    function automatic void release_lane(int c);
        lane_mode[c]       = MODE_IDLE;
        lane_dir[c]        = DIR_NONE;
        coil_word[c*4 +: 4] = 4'h0;
    endfunction

    function automatic void step_lane(int c);
        dir_t d;
        d = lane_dir[c];
        if (d == DIR_NONE)
            release_lane(c);
        else
        begin
            lane_phase[c] = (d == DIR_CW) ? lane_phase[c] + 2'd1 : lane_phase[c] - 2'd1;
            coil_word[c*4 +: 4] = PHASE_COILS[{lane_phase[c], 2'b00} +: 4];
        end
        // position moves even when the lane was released with no direction
        lane_pos[c] = (d == DIR_CW) ? lane_pos[c] + 16'd1 : lane_pos[c] - 16'd1;
    endfunction

    function automatic coil_beat_t predict_beat(req_kind_t kind, logic [1:0] idx,
                                                logic [7:0] steps, logic [7:0] tgt,
                                                logic [3:0] lim);
        coil_beat_t r;
        logic       busy;
        busy = 1'b0;
        if (kind == REQ_TICK)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                if (lane_mode[c] == MODE_MOVING)
                begin
                    busy = 1'b1;
                    if (lane_pos[c] != lane_tgt[c])
                        step_lane(c);
                    else
                        release_lane(c);
                end
                else if (lane_mode[c] == MODE_HOMING)
                begin
                    busy = 1'b1;
                    if (lim[c])
                        step_lane(c);
                    else
                    begin
                        lane_pos[c] = 16'd0;
                        release_lane(c);
                    end
                end
            end
        end
        else if (idx < CHANNELS)
        begin
            case (kind)
                REQ_REL:
                begin
                    lane_mode[idx] = MODE_MOVING;
                    lane_dir[idx]  = (!steps[7] && steps != 8'd0) ? DIR_CW : DIR_CCW;
                    lane_tgt[idx]  = lane_pos[idx] + {{8{steps[7]}}, steps};
                end
                REQ_ABS:
                begin
                    lane_mode[idx] = MODE_MOVING;
                    lane_dir[idx]  = ({8'h00, tgt} > lane_pos[idx]) ? DIR_CW : DIR_CCW;
                    lane_tgt[idx]  = {8'h00, tgt};
                end
                default:
                begin
                    lane_mode[idx] = MODE_HOMING;
                    lane_dir[idx]  = DIR_CW;
                    lane_tgt[idx]  = 16'd0;
                end
            endcase
        end
        r.coils    = coil_word;
        r.shift    = busy;
        r.all_idle = 1'b1;
        for (int c = 0; c < CHANNELS; c++)
            if (lane_mode[c] == MODE_MOVING || lane_mode[c] == MODE_HOMING)
                r.all_idle = 1'b0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        coil_beat_t want;
        if (!rst_n)
        begin
            for (int c = 0; c < MAX_CH; c++)
            begin
                lane_mode[c]  = MODE_HOMING;
                lane_dir[c]   = DIR_CW;
                lane_phase[c] = 2'd0;
                lane_pos[c]   = 16'd0;
                lane_tgt[c]   = 16'd0;
            end
            coil_word = 16'd0;
            coil_beats_q.delete();
            mismatches = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (coil_beats_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result beat with none expected: %h", $time, m_tdata);
                end
                else
                begin
                    want = coil_beats_q.pop_front();
                    if (m_tdata !== {6'b0, want.all_idle, want.shift, want.coils})
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch coil_word exp %h got %h, shift_out exp %b got %b, %s%b got %b, pad got %h",
                                     $time, want.coils, m_tdata[15:0], want.shift, m_tdata[16],
                                     "all_idle exp ", want.all_idle, m_tdata[17], m_tdata[23:18]);
                    end
                end
            end
            if (s_tvalid && s_tready)
                coil_beats_q.push_back(predict_beat(req_kind_t'(s_tuser), s_tdata[1:0],
                                                    s_tdata[9:2], s_tdata[17:10],
                                                    s_tdata[21:18]));
            errors  <= mismatches;
            pending <= coil_beats_q.size();
        end
    end

endmodule

// ----- sim/multi_stepper_phase_sequencer_top_tb.sv -----
// Testbench top for the stepper phase sequencer: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module multi_stepper_phase_sequencer_top_tb;
    import msps_pkg::*;

    localparam int RANDOM_BEATS = 900;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 4;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic [1:0]       s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;
    int               errors;
    int               pending;
    bit               hold_req;
    bit               hold_done;
    int               idle_cycles;

    always #6 clk = ~clk;

    multi_stepper_phase_sequencer_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    stepper_sequencer_checker sequencer_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending)
    );

    task automatic issue_request(req_kind_t kind, logic [1:0] idx, logic [7:0] steps,
                                 logic [7:0] tgt, logic [3:0] lim);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, lim, tgt, steps, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic rest_sender(int n);
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic random_request();
        int         pick;
        int         v;
        req_kind_t  kind;
        logic [7:0] steps;
        logic [7:0] tgt;
        pick = $urandom_range(0, 99);
        kind = (pick < 55) ? REQ_TICK : (pick < 73) ? REQ_REL : (pick < 87) ? REQ_ABS : REQ_HOME;
        v = $urandom_range(0, 12);
        steps = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'(v - 6);
        tgt = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
        // limit bits mostly open so homing runs a few steps
        issue_request(kind, 2'($urandom), steps, tgt, 4'($urandom | $urandom));
    endtask

    // receiver: random ready runs, one long hold once random traffic starts
    initial
    begin
        int run;
        m_tready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                m_tready <= 1'b1;
                run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 10);
                repeat (run) @(posedge clk);
                run = $urandom_range(0, 4);
                if (run != 0)
                begin
                    m_tready <= 1'b0;
                    repeat (run) @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        int sent;
        int burst;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = REQ_TICK;
        hold_req  = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // homing out of reset: all step, then half find the switch, then the rest
        issue_request(REQ_TICK, 2'd0, 8'h00, 8'h00, 4'hF);
        issue_request(REQ_TICK, 2'd3, 8'hFF, 8'hFF, 4'b1010);
        issue_request(REQ_TICK, 2'd0, 8'h00, 8'h00, 4'h0);
        // tick with every channel idle
        issue_request(REQ_TICK, 2'd1, 8'h00, 8'h00, 4'h0);
        issue_request(REQ_REL,  2'd0, 8'h7F, 8'h00, 4'h0);
        issue_request(REQ_REL,  2'd1, 8'h80, 8'hFF, 4'hF);
        // zero relative move clears on the next tick
        issue_request(REQ_REL,  2'd2, 8'h00, 8'h00, 4'h0);
        issue_request(REQ_ABS,  2'd3, 8'h00, 8'hFF, 4'h0);
        issue_request(REQ_TICK, 2'd0, 8'h00, 8'h00, 4'hF);
        issue_request(REQ_TICK, 2'd0, 8'h00, 8'h00, 4'hF);
        issue_request(REQ_TICK, 2'd0, 8'h00, 8'h00, 4'h0);
        issue_request(REQ_ABS,  2'd3, 8'hFF, 8'h00, 4'h0);
        issue_request(REQ_ABS,  2'd2, 8'h00, 8'h00, 4'h0);
        issue_request(REQ_HOME, 2'd1, 8'h00, 8'h00, 4'h0);
        issue_request(REQ_TICK, 2'd0, 8'h00, 8'h00, 4'b1101);
        issue_request(REQ_TICK, 2'd0, 8'h00, 8'h00, 4'b0000);
        issue_request(REQ_HOME, 2'd0, 8'h00, 8'h00, 4'hF);
        issue_request(REQ_HOME, 2'd3, 8'h00, 8'h00, 4'hF);
        issue_request(REQ_REL,  2'd2, 8'h01, 8'h00, 4'h0);
        issue_request(REQ_TICK, 2'd0, 8'h00, 8'h00, 4'b0110);
        issue_request(REQ_TICK, 2'd0, 8'h00, 8'h00, 4'b1001);
        issue_request(REQ_TICK, 2'd0, 8'h00, 8'h00, 4'h0);
        issue_request(REQ_TICK, 2'd0, 8'h00, 8'h00, 4'h0);
        drain_results();

        hold_req = 1'b1;
        sent = 0;
        while (sent < RANDOM_BEATS)
        begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < RANDOM_BEATS; k++)
            begin
                random_request();
                sent++;
                if (sent % 300 == 0)
                    drain_results();
            end
            rest_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
        end
        drain_results();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
src/msps_pkg.sv
src/msps_lane.sv
src/msps_merge.sv
src/multi_stepper_phase_sequencer_top.sv
sim/stepper_sequencer_checker.sv
sim/multi_stepper_phase_sequencer_top_tb.sv
